// File: hdl/hpfr_pkg.sv
package hpfr_pkg;

    localparam logic [7:0]  START_BYTE = 8'h91;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  ID_MAX     = 8'd3;
    localparam logic [7:0]  ID_TEMPS   = 8'd2;
    localparam logic [7:0]  ID_POWER   = 8'd3;
    localparam int          CAP_DEPTH  = 8;

    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_ID   = 2'd2;
    localparam logic [1:0] ST_LEN  = 2'd3;

    typedef struct packed {
        logic [1:0]                 status;
        logic [7:0]                 id;
        logic [CAP_DEPTH-1:0][7:0]  capture;
    } frame_evt_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic length_ok(input logic [7:0] n);
        return (n == 8'd13) || (n == 8'd14) || (n == 8'd19) || (n == 8'd21);
    endfunction

endpackage

// File: hdl/hpfr_front.sv
module hpfr_front
    import hpfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] rx_byte,
    output logic       push,
    output frame_evt_t evt
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ID,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t                    phase_reg;
    logic [4:0]                pos_reg;
    logic [4:0]                flen_reg;
    logic [7:0]                id_reg;
    logic [15:0]               crc_reg;
    logic [CAP_DEPTH-1:0][7:0] cap_reg;

    logic [15:0] crc_next;
    logic [4:0]  pos_next;
    logic [7:0]  len_plus;
    logic        cap_hit;
    logic [2:0]  cap_idx;

    assign crc_next = crc_feed(crc_reg, rx_byte);
    assign pos_next = (pos_reg == 5'd31) ? pos_reg : pos_reg + 5'd1;
    assign len_plus = rx_byte + 8'd1;
    assign cap_hit  = (pos_reg >= 5'd3) && (pos_reg <= 5'd10);
    assign cap_idx  = 3'(pos_reg - 5'd3);

    always_comb
    begin
        push        = 1'b0;
        evt.status  = ST_GOOD;
        evt.id      = id_reg;
        evt.capture = cap_reg;
        if (take)
        begin
            case (phase_reg)
                PH_ID:
                begin
                    if (rx_byte > ID_MAX)
                    begin
                        push       = 1'b1;
                        evt.status = ST_ID;
                        evt.id     = rx_byte;
                    end
                end
                PH_LEN:
                begin
                    if (!length_ok(len_plus))
                    begin
                        push       = 1'b1;
                        evt.status = ST_LEN;
                    end
                end
                PH_BODY:
                begin
                    if (pos_next >= flen_reg)
                    begin
                        push       = 1'b1;
                        evt.status = (crc_next != 16'h0000) ? ST_CRC : ST_GOOD;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= 5'd0;
            flen_reg  <= 5'd0;
            id_reg    <= 8'd0;
            crc_reg   <= CRC_INIT;
        end
        else if (take)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        crc_reg   <= crc_feed(CRC_INIT, rx_byte);
                        pos_reg   <= 5'd1;
                        phase_reg <= PH_ID;
                    end
                end
                PH_ID:
                begin
                    crc_reg   <= crc_next;
                    pos_reg   <= pos_next;
                    id_reg    <= rx_byte;
                    phase_reg <= (rx_byte > ID_MAX) ? PH_IDLE : PH_LEN;
                end
                PH_LEN:
                begin
                    crc_reg <= crc_next;
                    pos_reg <= pos_next;
                    if (length_ok(len_plus))
                    begin
                        flen_reg  <= len_plus[4:0];
                        phase_reg <= PH_BODY;
                    end
                    else
                    begin
                        phase_reg <= PH_IDLE;
                    end
                end
                PH_BODY:
                begin
                    crc_reg <= crc_next;
                    pos_reg <= pos_next;
                    if (pos_next >= flen_reg)
                    begin
                        phase_reg <= PH_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // frame bytes 3 to 10
    always_ff @(posedge clk)
    begin
        if (take && phase_reg == PH_BODY && cap_hit)
        begin
            cap_reg[cap_idx] <= rx_byte;
        end
    end

    a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (flen_reg >= 5'd13 && flen_reg <= 5'd21))
        else $error("body phase with bad frame length");

    a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN || phase_reg == PH_BODY) |-> (id_reg <= ID_MAX))
        else $error("frame in progress with bad id");

endmodule

// File: hdl/hpfr_queue.sv
module hpfr_queue
    import hpfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_evt_t push_evt,
    output logic       full,
    output logic       head_valid,
    input  logic       pop,
    output frame_evt_t head_evt
);

    frame_evt_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_evt   = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_evt;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// File: hdl/hpfr_back.sv
module hpfr_back
    import hpfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  frame_evt_t         head_evt,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         frame_status,
    output logic [7:0]         frame_id,
    output logic signed [15:0] supply_tenths,
    output logic signed [15:0] return_tenths,
    output logic signed [15:0] outside_tenths,
    output logic               temps_valid,
    output logic [7:0]         compressor_speed,
    output logic [7:0]         power_units,
    output logic               power_valid
);

    logic        valid_reg;
    logic [1:0]  status_reg;
    logic [7:0]  id_reg;
    logic [15:0] supply_reg;
    logic [15:0] return_reg;
    logic [15:0] outside_reg;
    logic        temps_seen_reg;
    logic [7:0]  speed_reg;
    logic [7:0]  power_reg;
    logic        power_seen_reg;

    logic good;

    assign pop  = head_valid && (!valid_reg || !res_stall);
    assign good = (head_evt.status == ST_GOOD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            status_reg     <= ST_GOOD;
            id_reg         <= 8'd0;
            supply_reg     <= 16'd0;
            return_reg     <= 16'd0;
            outside_reg    <= 16'd0;
            temps_seen_reg <= 1'b0;
            speed_reg      <= 8'd0;
            power_reg      <= 8'd0;
            power_seen_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg  <= 1'b1;
                status_reg <= head_evt.status;
                id_reg     <= head_evt.id;
                if (good && head_evt.id == ID_TEMPS)
                begin
                    supply_reg     <= {head_evt.capture[1], head_evt.capture[0]};
                    return_reg     <= {head_evt.capture[3], head_evt.capture[2]};
                    outside_reg    <= {head_evt.capture[5], head_evt.capture[4]};
                    temps_seen_reg <= 1'b1;
                end
                else if (good && head_evt.id == ID_POWER)
                begin
                    speed_reg      <= head_evt.capture[6];
                    power_reg      <= head_evt.capture[7];
                    power_seen_reg <= 1'b1;
                end
            end
            else if (!res_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid        = valid_reg;
    assign frame_status     = status_reg;
    assign frame_id         = id_reg;
    assign supply_tenths    = signed'(supply_reg);
    assign return_tenths    = signed'(return_reg);
    assign outside_tenths   = signed'(outside_reg);
    assign temps_valid      = temps_seen_reg;
    assign compressor_speed = speed_reg;
    assign power_units      = power_reg;
    assign power_valid      = power_seen_reg;

    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg)
        else $error("popped beat not shown");

endmodule

// File: hdl/heat_pump_frame_receiver_unit.sv
// heat pump frame receiver
// input channel: rx_valid / rx_stall carry one line byte per beat on rx_byte.
// the front parser hunts for the start byte, checks id and length, runs the
// crc-16 over the frame and keeps frame bytes 3 to 10; at each frame end or
// abort it pushes one record into a two-entry queue.
// the back part pops records, updates the held temperatures, speed and power
// on good id 2 and id 3 frames, and shows one result beat on res_valid /
// res_stall with the status, the id and all held values.
// throughput: one byte per cycle while rx_stall is low; the crc update is one
// unrolled byte step. result path: the record ending or aborting a frame is
// queued, then popped into the result register, which drives res_valid.
// stall: while res_stall holds, the result beat holds; the front takes bytes
// until the queue holds two records, then rx_stall rises until one drains.
// reset: parser waits for a start byte, crc at 0xffff, held values zero,
// valid flags clear, queue empty, no result shown.
module heat_pump_frame_receiver_unit
    import hpfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         frame_status,
    output logic [7:0]         frame_id,
    output logic signed [15:0] supply_tenths,
    output logic signed [15:0] return_tenths,
    output logic signed [15:0] outside_tenths,
    output logic               temps_valid,
    output logic [7:0]         compressor_speed,
    output logic [7:0]         power_units,
    output logic               power_valid
);

    logic       take;
    logic       push;
    logic       full;
    logic       head_valid;
    logic       pop;
    frame_evt_t push_evt;
    frame_evt_t head_evt;

    assign rx_stall = full;
    assign take     = rx_valid && !full;

    hpfr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .push    (push),
        .evt     (push_evt)
    );

    hpfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_evt   (push_evt),
        .full       (full),
        .head_valid (head_valid),
        .pop        (pop),
        .head_evt   (head_evt)
    );

    hpfr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head_evt         (head_evt),
        .pop              (pop),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .frame_status     (frame_status),
        .frame_id         (frame_id),
        .supply_tenths    (supply_tenths),
        .return_tenths    (return_tenths),
        .outside_tenths   (outside_tenths),
        .temps_valid      (temps_valid),
        .compressor_speed (compressor_speed),
        .power_units      (power_units),
        .power_valid      (power_valid)
    );

endmodule
